// File: rtl/tsc_pkg.sv
package tsc_pkg;

    localparam int ANGLE_W   = 16;
    localparam int VALUE_W   = 24;
    localparam int TC_W      = 4;
    localparam int TC_RESET  = 4;
    localparam int MAX_TERMS_DEFAULT = 12;

    // running magnitude |x|^k/k!, unsigned Q.30; stays below 16.0 for |x| <= 4
    localparam int MAG_FRAC  = 30;
    localparam int M_W       = 36;
    localparam int ANG_FRAC  = 13;
    localparam int REC_FRAC  = 24;
    localparam int REC_W     = 25;
    localparam int MB_W      = 16;          // narrow multiplier operand
    localparam int PROD_W    = M_W + MB_W;
    localparam int SUM_W     = 38;          // signed Q.30 partial sum
    localparam int OUT_SHIFT = MAG_FRAC - 16;
    localparam int IDX_W     = 5;           // term index, covers 2*16 terms

    typedef enum logic [2:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_X,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_FINAL,
        OP_ROUND
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_X,
        S_MUL_LO,
        S_MUL_HI,
        S_FINAL,
        S_ROUND
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [IDX_W-1:0] term_k;   // index of the magnitude held now
        logic [IDX_W-1:0] recip_k;  // exponent step being formed
    } ctrl_t;

    // round(2^24 / k), Q1.24
    function automatic logic [REC_W-1:0] recip(input logic [IDX_W-1:0] k);
        logic [REC_W-1:0] r;
        unique case (k)
            5'd0:  r = 25'd0;
            5'd1:  r = 25'd16777216;
            5'd2:  r = 25'd8388608;
            5'd3:  r = 25'd5592405;
            5'd4:  r = 25'd4194304;
            5'd5:  r = 25'd3355443;
            5'd6:  r = 25'd2796203;
            5'd7:  r = 25'd2396745;
            5'd8:  r = 25'd2097152;
            5'd9:  r = 25'd1864135;
            5'd10: r = 25'd1677722;
            5'd11: r = 25'd1525201;
            5'd12: r = 25'd1398101;
            5'd13: r = 25'd1290555;
            5'd14: r = 25'd1198373;
            5'd15: r = 25'd1118481;
            5'd16: r = 25'd1048576;
            5'd17: r = 25'd986895;
            5'd18: r = 25'd932068;
            5'd19: r = 25'd883011;
            5'd20: r = 25'd838861;
            5'd21: r = 25'd798915;
            5'd22: r = 25'd762601;
            5'd23: r = 25'd729444;
            5'd24: r = 25'd699051;
            5'd25: r = 25'd671089;
            5'd26: r = 25'd645278;
            5'd27: r = 25'd621378;
            5'd28: r = 25'd599186;
            5'd29: r = 25'd578525;
            5'd30: r = 25'd559241;
            5'd31: r = 25'd541201;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/tsc_if.sv
interface tsc_req_if import tsc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      func;
    logic signed [ANGLE_W-1:0] angle;

    modport source (output valid, func, angle, input ready);
    modport sink   (input valid, func, angle, output ready);
endinterface

interface tsc_rsp_if import tsc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [VALUE_W-1:0] value;
    logic                      saturated;

    modport source (output valid, value, saturated, input ready);
    modport sink   (input valid, value, saturated, output ready);
endinterface

// File: rtl/taylor_sine_cosine.sv
// Truncated Taylor series sine / cosine. A request gives func (0 sine, 1 cosine)
// and a signed Q3.13 angle in radians; the response gives the partial sum of
// the first term_count terms as signed Q7.16, rounded half away from zero, with
// saturated set if the sum was clipped. term_count of zero returns zero and
// counts above MAX_TERMS are treated as MAX_TERMS. One request is worked at a
// time: each exponent step takes three passes through a single shared
// 36x16 multiplier (|x| once, the table reciprocal 1/k in two halves), so a
// request with last exponent L = 2n-1 (sine) or 2n-2 (cosine) occupies the
// block for L such steps, then a final accumulate and the rounding; a zero
// term count goes straight to the rounding. A finished response sits in the
// output register, so the next request is accepted while that response waits
// to be taken. term_count may only be written while no request is in flight.
module taylor_sine_cosine import tsc_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_wr_en,
    input  logic [TC_W-1:0]  cfg_wr_data,
    tsc_req_if.sink          req,
    tsc_rsp_if.source        rsp
);

    logic [TC_W-1:0] term_count_reg;
    ctrl_t           ctrl;

    // configuration: number of series terms
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            term_count_reg <= TC_W'(TC_RESET);
        end
        else if (cfg_wr_en)
        begin
            term_count_reg <= cfg_wr_data;
        end
    end

    // sequencer: exponent step counter and handshakes
    tsc_ctrl #(
        .MAX_TERMS (MAX_TERMS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (req.valid),
        .in_ready   (req.ready),
        .in_func    (req.func),
        .term_count (term_count_reg),
        .out_valid  (rsp.valid),
        .out_ready  (rsp.ready),
        .ctrl       (ctrl)
    );

    // shared multiplier, magnitude recurrence, accumulator, output rounding
    tsc_datapath u_datapath (
        .clk       (clk),
        .ctrl      (ctrl),
        .in_func   (req.func),
        .in_angle  (req.angle),
        .value     (rsp.value),
        .saturated (rsp.saturated)
    );

endmodule

// File: rtl/tsc_ctrl.sv
module tsc_ctrl import tsc_pkg::*; #(
    parameter int MAX_TERMS = MAX_TERMS_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            in_func,
    input  logic [TC_W-1:0] term_count,
    output logic            out_valid,
    input  logic            out_ready,
    output ctrl_t           ctrl
);

    localparam int K_W  = $clog2(2 * MAX_TERMS);
    localparam int N_W  = TC_W + 1;
    localparam int L_W  = N_W + 1;

    state_t         state_reg, state_next;
    logic [K_W-1:0] k_reg, k_next;
    logic [K_W-1:0] last_reg, last_next;
    logic           out_valid_reg, out_valid_next;

    logic [N_W-1:0] n_clamp;
    logic [L_W-1:0] last_full;
    logic [K_W-1:0] last_new;
    logic [K_W-1:0] k_inc;

    // terms beyond the build limit are dropped
    assign n_clamp   = ({1'b0, term_count} > N_W'(MAX_TERMS)) ? N_W'(MAX_TERMS)
                                                             : {1'b0, term_count};
    // sine ends at exponent 2n-1, cosine at 2n-2
    assign last_full = {n_clamp, 1'b0} - L_W'(2) + L_W'(!in_func);
    assign last_new  = last_full[K_W-1:0];
    assign k_inc     = k_reg + K_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            last_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        ctrl.op        = OP_NONE;
        ctrl.term_k    = IDX_W'(k_reg);
        ctrl.recip_k   = IDX_W'(k_inc);

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.op   = OP_LOAD;
                    k_next    = '0;
                    last_next = last_new;
                    if (n_clamp == '0)
                        state_next = S_ROUND;
                    else if (last_new == '0)
                        state_next = S_FINAL;
                    else
                        state_next = S_MUL_X;
                end
            end
            S_MUL_X:
            begin
                ctrl.op    = OP_MUL_X;
                state_next = S_MUL_LO;
            end
            S_MUL_LO:
            begin
                ctrl.op    = OP_MUL_LO;
                state_next = S_MUL_HI;
            end
            S_MUL_HI:
            begin
                ctrl.op = OP_MUL_HI;
                k_next  = k_inc;
                if (k_inc == last_reg)
                    state_next = S_FINAL;
                else
                    state_next = S_MUL_X;
            end
            S_FINAL:
            begin
                ctrl.op    = OP_FINAL;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    ctrl.op        = OP_ROUND;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule

// File: rtl/tsc_datapath.sv
module tsc_datapath import tsc_pkg::*; (
    input  logic                      clk,
    input  ctrl_t                     ctrl,
    input  logic                      in_func,
    input  logic signed [ANGLE_W-1:0] in_angle,
    output logic signed [VALUE_W-1:0] value,
    output logic                      saturated
);

    localparam int FULL_W = PROD_W + MB_W;

    logic                      func_reg;
    logic                      xneg_reg;
    logic [ANGLE_W-1:0]        ax_reg;
    logic [M_W-1:0]            m_reg;
    logic [M_W-1:0]            p1_reg;
    logic [PROD_W-1:0]         acc_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic                      sat_reg;

    logic [REC_W-1:0]  rec;
    logic [M_W-1:0]    mul_a;
    logic [MB_W-1:0]   mul_b;
    logic [PROD_W-1:0] prod;
    logic [PROD_W:0]   p1_round;
    logic [FULL_W-1:0] full;
    logic [FULL_W-1:0] m_round;

    logic                    term_sel;
    logic                    term_neg;
    logic signed [SUM_W-1:0] term;
    logic signed [SUM_W-1:0] sum_add;

    logic               sum_neg;
    logic [SUM_W-1:0]   mag;
    logic [SUM_W-1:0]   mag_round;
    logic [VALUE_W-1:0] r;
    logic [VALUE_W-1:0] val_next;
    logic               sat_next;

    // one shared multiplier: m*|x|, then p1*R in two halves
    assign rec = recip(ctrl.recip_k);

    always_comb
    begin
        mul_a = p1_reg;
        mul_b = rec[MB_W-1:0];
        unique case (ctrl.op)
            OP_MUL_X:
            begin
                mul_a = m_reg;
                mul_b = ax_reg;
            end
            OP_MUL_HI:
            begin
                mul_b = MB_W'(rec[REC_W-1:MB_W]);
            end
            default:
            begin
                mul_b = rec[MB_W-1:0];
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign p1_round = ({1'b0, prod} + (PROD_W+1)'(1 << (ANG_FRAC - 1))) >> ANG_FRAC;
    assign full     = FULL_W'(acc_reg) + (FULL_W'(prod) << MB_W);
    assign m_round  = (full + FULL_W'(1 << (REC_FRAC - 1))) >> REC_FRAC;

    // term k is in the series when its parity matches the function
    assign term_sel = ctrl.term_k[0] != func_reg;
    assign term_neg = ctrl.term_k[1] ^ (xneg_reg & ctrl.term_k[0]);
    assign term     = signed'(SUM_W'(m_reg));
    assign sum_add  = !term_sel ? sum_reg
                    : term_neg  ? sum_reg - term
                    :             sum_reg + term;

    // round half away from zero on the magnitude, then clip
    assign sum_neg   = sum_reg[SUM_W-1];
    assign mag       = sum_neg ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign mag_round = (mag + SUM_W'(1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
    assign r         = mag_round[VALUE_W-1:0];

    always_comb
    begin
        sat_next = 1'b0;
        if (sum_neg)
        begin
            if (mag_round > SUM_W'(1 << (VALUE_W - 1)))
            begin
                val_next = {1'b1, {(VALUE_W-1){1'b0}}};
                sat_next = 1'b1;
            end
            else
            begin
                val_next = -r;
            end
        end
        else
        begin
            if (mag_round > SUM_W'((1 << (VALUE_W - 1)) - 1))
            begin
                val_next = {1'b0, {(VALUE_W-1){1'b1}}};
                sat_next = 1'b1;
            end
            else
            begin
                val_next = r;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD:
            begin
                func_reg <= in_func;
                xneg_reg <= in_angle[ANGLE_W-1];
                ax_reg   <= in_angle[ANGLE_W-1] ? ANGLE_W'(-in_angle) : ANGLE_W'(in_angle);
                m_reg    <= M_W'(1) << MAG_FRAC;
                sum_reg  <= '0;
            end
            OP_MUL_X:
            begin
                sum_reg <= sum_add;
                p1_reg  <= p1_round[M_W-1:0];
            end
            OP_MUL_LO:
            begin
                acc_reg <= prod;
            end
            OP_MUL_HI:
            begin
                m_reg <= m_round[M_W-1:0];
            end
            OP_FINAL:
            begin
                sum_reg <= sum_add;
            end
            OP_ROUND:
            begin
                value_reg <= signed'(val_next);
                sat_reg   <= sat_next;
            end
            OP_NONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign value     = value_reg;
    assign saturated = sat_reg;

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps

module tb;
    import tsc_pkg::*;

    // function select codes on the request
    localparam logic FUNC_SIN = 1'b0;
    localparam logic FUNC_COS = 1'b1;

    // fixed-point positions used by the series predictor
    localparam int Q_MAG = 30;      // running magnitude |x|^k/k!
    localparam int Q_ANG = 13;      // request angle
    localparam int Q_REC = 24;      // reciprocal 1/k
    localparam int Q_OUT = 16;      // response value

    localparam int CYCLE_LIMIT = 500000;
    localparam int SETTLE_CYCLES = 80;      // longer than the longest request
    localparam int RANDOM_PER_PHASE = 78;
    localparam int CALM_FROM = 830;         // no idling from this random request on

    typedef enum logic [1:0] {
        STEP_REQ,       // send one request
        STEP_CFG,       // write term_count once the block is empty
        STEP_DRAIN      // hold off until every response is back
    } step_kind_t;

    typedef struct {
        step_kind_t        kind;
        logic              func;
        logic signed [15:0] angle;
        logic [TC_W-1:0]   terms;
        bit                calm;
    } step_t;

    typedef struct {
        logic signed [VALUE_W-1:0] value;
        logic                      saturated;
    } series_t;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [TC_W-1:0]   cfg_wr_data;

    tsc_req_if req ();
    tsc_rsp_if rsp ();

    taylor_sine_cosine DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req),
        .rsp         (rsp)
    );

    always #10 clk = ~clk;

    step_t           plan[$];           // stimulus not yet handed to the block
    series_t         pending_sums[$];   // predicted responses, oldest first
    logic [TC_W-1:0] terms_now = TC_RESET;
    int              reqs_sent;         // requests accepted, driver side
    int              sums_taken;        // responses accepted, NBA-updated
    int              errors = 0;
    int              idle_pct = 0;      // current idling odds, percent
    bit              quiet = 1'b0;      // end of run: no idling at all
    int              gap_left;
    int              stall_left;
    int              cycles = 0;

    // ------------------------------------------------------------------
    // Series predictor. The running magnitude |x|^k/k! is stepped one
    // exponent at a time: times |x| (rounded back to Q.30), then times the
    // rounded reciprocal 1/k. Terms alternate in sign; an odd power of a
    // negative angle flips the sign once more. The exact Q.30 sum is
    // rounded half away from zero to Q7.16 and clipped.
    // ------------------------------------------------------------------
    function automatic series_t series_sum(input logic cos_sel,
                                           input logic signed [15:0] ang,
                                           input logic [TC_W-1:0] terms);
        series_t          res;
        longint unsigned  ax;
        longint unsigned  mag;
        longint unsigned  recip;
        longint unsigned  out_mag;
        longint           acc;
        int               n;
        int               last;
        int               j;
        bit               xneg;
        bit               tneg;
        res.value = '0;
        res.saturated = 1'b0;
        n = (terms > MAX_TERMS_DEFAULT) ? MAX_TERMS_DEFAULT : int'(terms);
        if (n == 0)
            return res;
        xneg = ang[15];
        ax = xneg ? longint'(-longint'(ang)) : longint'(ang);
        last = 2 * n - 2 + ((cos_sel == FUNC_COS) ? 0 : 1);
        mag = 64'd1 << Q_MAG;
        acc = 0;
        j = 0;
        for (int k = 0; k <= last; k++)
        begin
            if (k > 0)
            begin
                mag = (mag * ax + (64'd1 << (Q_ANG - 1))) >> Q_ANG;
                // round(2^24 / k)
                recip = ((64'd1 << (Q_REC + 1)) + k) / (2 * k);
                mag = (mag * recip + (64'd1 << (Q_REC - 1))) >> Q_REC;
            end
            if ((k % 2) == ((cos_sel == FUNC_COS) ? 0 : 1))
            begin
                tneg = ((j % 2) == 1) ^ (xneg && (k % 2) == 1);
                acc = tneg ? acc - longint'(mag) : acc + longint'(mag);
                j++;
            end
        end
        out_mag = (acc < 0) ? longint'(-acc) : longint'(acc);
        out_mag = (out_mag + (64'd1 << (Q_MAG - Q_OUT - 1))) >> (Q_MAG - Q_OUT);
        if (acc < 0)
        begin
            if (out_mag > 64'd8388608)
            begin
                out_mag = 64'd8388608;
                res.saturated = 1'b1;
            end
            res.value = VALUE_W'(-longint'(out_mag));
        end
        else
        begin
            if (out_mag > 64'd8388607)
            begin
                out_mag = 64'd8388607;
                res.saturated = 1'b1;
            end
            res.value = VALUE_W'(out_mag);
        end
        return res;
    endfunction

    task automatic add_req(input logic f, input logic signed [15:0] a, input bit calm);
        step_t s;
        s.kind = STEP_REQ;
        s.func = f;
        s.angle = a;
        s.terms = '0;
        s.calm = calm;
        plan.push_back(s);
    endtask

    task automatic add_cfg(input logic [TC_W-1:0] t);
        step_t s;
        s.kind = STEP_CFG;
        s.func = FUNC_SIN;
        s.angle = '0;
        s.terms = t;
        s.calm = 1'b0;
        plan.push_back(s);
    endtask

    // mostly uniform angles, with a share of the extremes and of small angles
    function automatic logic signed [15:0] pick_angle();
        logic signed [15:0] a;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 4))
                    0: a = 16'sh7FFF;
                    1: a = 16'sh8000;
                    2: a = 16'sh0000;
                    3: a = 16'shFFFF;
                    default: a = 16'sh0001;
                endcase
            end
            1, 2:    a = 16'($signed($urandom_range(0, 2047)) - 1024);
            default: a = 16'($urandom_range(0, 65535));
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Request driver. A request stays up until taken. A term_count write
    // or a drain step waits until every request sent so far has its
    // response back (sums_taken is NBA-updated, so the compare sees the
    // count from before this edge). The expected term count moves with
    // the write, which lands before any following request can be taken.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        logic v_nxt;
        logic we_nxt;
        logic fired;
        if (!rst_n)
        begin
            req.valid   <= 1'b0;
            req.func    <= FUNC_SIN;
            req.angle   <= '0;
            cfg_wr_en   <= 1'b0;
            cfg_wr_data <= '0;
            reqs_sent = 0;
            gap_left = 0;
        end
        else
        begin
            fired = req.valid && req.ready;
            v_nxt = req.valid && !fired;
            we_nxt = 1'b0;
            if (fired)
            begin
                reqs_sent++;
                if (!quiet && $urandom_range(0, 99) < idle_pct)
                    gap_left = $urandom_range(1, 3);
            end
            if (!v_nxt)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (plan.size() > 0)
                begin
                    case (plan[0].kind)
                        STEP_REQ:
                        begin
                            v_nxt = 1'b1;
                            req.func  <= plan[0].func;
                            req.angle <= plan[0].angle;
                            quiet     <= plan[0].calm;
                            void'(plan.pop_front());
                        end
                        STEP_CFG:
                        begin
                            if (!fired && reqs_sent == sums_taken)
                            begin
                                we_nxt = 1'b1;
                                cfg_wr_data <= plan[0].terms;
                                terms_now   <= plan[0].terms;
                                void'(plan.pop_front());
                            end
                        end
                        STEP_DRAIN:
                        begin
                            if (!fired && reqs_sent == sums_taken)
                                void'(plan.pop_front());
                        end
                        default: ;
                    endcase
                end
            end
            req.valid <= v_nxt;
            cfg_wr_en <= we_nxt;
        end
    end

    // response side back-pressure: ready drops in random bursts while idling is allowed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp.ready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 99) < idle_pct)
        begin
            stall_left = $urandom_range(0, 2);
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on each accepted request, checks each accepted
    // response against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        series_t e;
        if (!rst_n)
            sums_taken <= 0;
        else
        begin
            if (req.valid && req.ready)
                pending_sums.push_back(series_sum(req.func, req.angle, terms_now));
            if (rsp.valid && rsp.ready)
            begin
                if (pending_sums.size() == 0)
                begin
                    $display("%0t unexpected response: expected none actual value %0d sat %0b",
                             $time, rsp.value, rsp.saturated);
                    errors++;
                end
                else
                begin
                    e = pending_sums.pop_front();
                    if (rsp.value !== e.value)
                    begin
                        $display("%0t value mismatch: expected %0d actual %0d",
                                 $time, e.value, rsp.value);
                        errors++;
                    end
                    if (rsp.saturated !== e.saturated)
                    begin
                        $display("%0t saturated mismatch: expected %0b actual %0b",
                                 $time, e.saturated, rsp.saturated);
                        errors++;
                    end
                end
                sums_taken <= sums_taken + 1;
            end
        end
    end

    // cycle limit, and the idling odds are redrawn among 0, 15, 30 and 45 percent so that
    // busy stretches alternate with ones that have no gaps at all
    always @(posedge clk)
    begin
        cycles++;
        if (cycles % 64 == 0)
        begin
            case ($urandom_range(0, 3))
                0:       idle_pct <= 0;
                1:       idle_pct <= 15;
                2:       idle_pct <= 30;
                default: idle_pct <= 45;
            endcase
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus plan, reset, end of run.
    // ------------------------------------------------------------------
    initial
    begin
        logic [TC_W-1:0] phase_terms[12];
        int n_rand;
        step_t drain;
        phase_terms = '{12, 0, 15, 1, 6, 12, 3, 9, 14, 2, 12, 5};
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        req.valid = 1'b0;
        req.func = FUNC_SIN;
        req.angle = '0;
        rsp.ready = 1'b0;

        // reset term count (4): angle extremes, zero, +/- one LSB
        add_req(FUNC_SIN, 16'sh7FFF, 1'b0);
        add_req(FUNC_COS, 16'sh7FFF, 1'b0);
        add_req(FUNC_SIN, 16'sh8000, 1'b0);
        add_req(FUNC_COS, 16'sh8000, 1'b0);
        add_req(FUNC_SIN, 16'sh0000, 1'b0);
        add_req(FUNC_COS, 16'sh0000, 1'b0);
        add_req(FUNC_SIN, 16'sh0001, 1'b0);
        add_req(FUNC_COS, 16'shFFFF, 1'b0);
        // zero terms gives zero whatever the angle
        add_cfg(4'd0);
        add_req(FUNC_SIN, 16'sd12345, 1'b0);
        add_req(FUNC_COS, 16'sh8000, 1'b0);
        // full series
        add_cfg(4'd12);
        add_req(FUNC_SIN, 16'sh7FFF, 1'b0);
        add_req(FUNC_COS, 16'sh8000, 1'b0);
        add_req(FUNC_SIN, 16'sh8000, 1'b0);
        add_req(FUNC_COS, 16'sd25736, 1'b0);     // about pi
        add_req(FUNC_SIN, -16'sd12868, 1'b0);    // about -pi/2
        // count above the limit is clamped to the limit
        add_cfg(4'd15);
        add_req(FUNC_SIN, 16'sh8000, 1'b0);
        add_req(FUNC_COS, 16'sh7FFF, 1'b0);
        // single term: x for sine, 1.0 for cosine
        add_cfg(4'd1);
        add_req(FUNC_SIN, 16'shFFFF, 1'b0);
        add_req(FUNC_COS, 16'sh7FFF, 1'b0);
        add_req(FUNC_SIN, 16'sh7FFF, 1'b0);

        // random phases, one term count each; a full drain halfway through one
        n_rand = 0;
        foreach (phase_terms[p])
        begin
            add_cfg(phase_terms[p]);
            for (int i = 0; i < RANDOM_PER_PHASE; i++)
            begin
                if (p == 5 && i == RANDOM_PER_PHASE / 2)
                begin
                    drain.kind = STEP_DRAIN;
                    drain.func = FUNC_SIN;
                    drain.angle = '0;
                    drain.terms = '0;
                    drain.calm = 1'b0;
                    plan.push_back(drain);
                end
                add_req(logic'($urandom_range(0, 1)), pick_angle(), n_rand >= CALM_FROM);
                n_rand++;
            end
        end

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // everything sent and every response back
        while (!(plan.size() == 0 && !req.valid && reqs_sent == sums_taken))
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (pending_sums.size() != 0)
        begin
            $display("%0t %0d responses never arrived", $time, pending_sums.size());
            errors++;
        end
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
